// ===== sv/calendar_date_add_days_assert.svh =====
// Assertion helpers shared by the calendar date block.
// Each check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH

// Same-cycle implication.
`define CDA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cda_pkg.sv =====
`timescale 1ns / 1ps

package cda_pkg;

  localparam int DAY_COUNT_BITS = 16;
  localparam int YEAR_W         = 16;
  localparam int MONTH_W        = 4;
  localparam int DAY_W          = 5;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
  localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
  localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
  localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic [DAY_W-1:0] LEN_31 = 5'd31;
  localparam logic [DAY_W-1:0] LEN_30 = 5'd30;
  localparam logic [DAY_W-1:0] LEN_29 = 5'd29;
  localparam logic [DAY_W-1:0] LEN_28 = 5'd28;

  // 25 * INV_25 == 1 mod 2^16; y is a multiple of 25 iff y * INV_25 (mod 2^16) <= MAX_Q25
  localparam logic [YEAR_W-1:0] INV_25  = 16'd23593;
  localparam logic [YEAR_W-1:0] MAX_Q25 = 16'd2621;

  localparam logic CMD_SET = 1'b0;
  localparam logic CMD_ADD = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEAP,
    ST_CLAMP,
    ST_STEP,
    ST_DONE
  } cda_state_t;

  typedef struct packed {
    logic load;
    logic leap_upd;
    logic clamp;
    logic step;
    logic out_load;
  } cda_cmd_t;

  typedef struct packed {
    logic in_add;
    logic add;
    logic overrun;
    logic wrap;
  } cda_status_t;

  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    logic                div4;
    logic                div100;
    logic                div400;
    prod   = y * INV_25;
    div25  = (prod[YEAR_W-1:0] <= MAX_Q25);
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && div25;
    div400 = (y[3:0] == 4'd0) && div25;
    return div400 || (div4 && !div100);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_30;
      MONTH_FEB: len = leap ? LEN_29 : LEN_28;
      default:   len = LEN_31;
    endcase
    return len;
  endfunction

endpackage

// ===== sv/cda_ctrl.sv =====
`timescale 1ns / 1ps

module cda_ctrl
  import cda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  cda_status_t status,
  output cda_cmd_t    cmd
);

  cda_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_blocked;

  assign out_blocked = out_valid_r && out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (status.in_add == CMD_ADD) ? ST_STEP : ST_LEAP;
        end
      end
      ST_LEAP: begin
        state_nxt = (status.add == CMD_ADD) ? ST_STEP : ST_CLAMP;
      end
      ST_CLAMP: state_nxt = ST_DONE;
      ST_STEP: begin
        if (status.overrun && status.wrap) begin
          // year changed: refresh the leap flag before the next month
          state_nxt = ST_LEAP;
        end else if (!status.overrun) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_blocked) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == ST_IDLE) && in_valid;
    cmd.leap_upd = (state_r == ST_LEAP);
    cmd.clamp    = (state_r == ST_CLAMP);
    cmd.step     = (state_r == ST_STEP);
    cmd.out_load = (state_r == ST_DONE) && !out_blocked;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== sv/cda_dp.sv =====
`timescale 1ns / 1ps

module cda_dp
  import cda_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_command,
  input  logic [YEAR_W-1:0]   in_new_year,
  input  logic [MONTH_W-1:0]  in_new_month,
  input  logic [DAY_W-1:0]    in_new_day,
  input  logic [15:0]         in_day_count,
  output logic [YEAR_W-1:0]   out_year_out,
  output logic [MONTH_W-1:0]  out_month_out,
  output logic [DAY_W-1:0]    out_day_out,
  input  cda_cmd_t            cmd,
  output cda_status_t         status
);

  logic [YEAR_W-1:0]         year_r, year_nxt;
  logic [MONTH_W-1:0]        month_r, month_nxt;
  logic [DAY_W-1:0]          day_r, day_nxt;
  logic                      leap_r, leap_nxt;
  logic                      add_r, add_nxt;
  logic [DAY_COUNT_BITS-1:0] left_r, left_nxt;
  logic [YEAR_W-1:0]         oyear_r;
  logic [MONTH_W-1:0]        omonth_r;
  logic [DAY_W-1:0]          oday_r;

  logic [DAY_W-1:0]          len;
  logic [DAY_COUNT_BITS:0]   sum;
  logic [DAY_W-1:0]          rest;
  logic                      overrun;
  logic                      wrap;

  assign len     = month_len(leap_r, month_r);
  assign sum     = {{(DAY_COUNT_BITS + 1 - DAY_W){1'b0}}, day_r}
                 + {1'b0, left_r};
  assign overrun = (sum > {{(DAY_COUNT_BITS + 1 - DAY_W){1'b0}}, len});
  assign rest    = len - day_r;
  assign wrap    = (month_r >= MONTH_DEC);

  always_comb begin
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    leap_nxt  = leap_r;
    add_nxt   = add_r;
    left_nxt  = left_r;
    if (cmd.load) begin
      add_nxt = in_command;
      if (in_command == CMD_SET) begin
        year_nxt = in_new_year;
        if (in_new_month < MONTH_JAN) begin
          month_nxt = MONTH_JAN;
        end else if (in_new_month > MONTH_DEC) begin
          month_nxt = MONTH_DEC;
        end else begin
          month_nxt = in_new_month;
        end
        day_nxt = (in_new_day == '0) ? DAY_W'(1) : in_new_day;
      end else begin
        left_nxt = in_day_count[DAY_COUNT_BITS-1:0];
      end
    end
    if (cmd.leap_upd) begin
      leap_nxt = is_leap(year_r);
    end
    if (cmd.clamp && (day_r > len)) begin
      day_nxt = len;
    end
    if (cmd.step) begin
      if (overrun) begin
        // drop the rest of this month and roll over
        left_nxt = left_r - {{(DAY_COUNT_BITS - DAY_W){1'b0}}, rest};
        day_nxt  = '0;
        if (wrap) begin
          month_nxt = MONTH_JAN;
          year_nxt  = year_r + YEAR_W'(1);
        end else begin
          month_nxt = month_r + MONTH_W'(1);
        end
      end else begin
        day_nxt = sum[DAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      year_r  <= '0;
      month_r <= MONTH_JAN;
      day_r   <= DAY_W'(1);
      leap_r  <= 1'b1;
      add_r   <= CMD_SET;
    end else begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      leap_r  <= leap_nxt;
      add_r   <= add_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    if (cmd.out_load) begin
      oyear_r  <= year_r;
      omonth_r <= month_r;
      oday_r   <= day_r;
    end
  end

  always_comb begin
    status         = '0;
    status.in_add  = in_command;
    status.add     = add_r;
    status.overrun = overrun;
    status.wrap    = wrap;
  end

  assign out_year_out  = oyear_r;
  assign out_month_out = omonth_r;
  assign out_day_out   = oday_r;

endmodule

// ===== sv/calendar_date_add_days.sv =====
// Sequencing: after acceptance a set transaction passes through LEAP, CLAMP and DONE; an add
// repeats STEP for each month crossed, with LEAP at each year crossed, then goes to DONE.
// Only one transaction is in flight at a time: in_stall stays high until the FSM is idle.
// The output register lets the next transaction start while a result waits.
// Reset (synchronous, rst_n low): date 0000-01-01, idle, no result pending.
`timescale 1ns / 1ps

`include "calendar_date_add_days_assert.svh"

module calendar_date_add_days
  import cda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_command,
  input  logic [YEAR_W-1:0]  in_new_year,
  input  logic [MONTH_W-1:0] in_new_month,
  input  logic [DAY_W-1:0]   in_new_day,
  input  logic [15:0]        in_day_count,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [YEAR_W-1:0]  out_year_out,
  output logic [MONTH_W-1:0] out_month_out,
  output logic [DAY_W-1:0]   out_day_out
);

  cda_cmd_t    cmd;
  cda_status_t status;
  logic        out_date_ok;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cda_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_command    (in_command),
    .in_new_year   (in_new_year),
    .in_new_month  (in_new_month),
    .in_new_day    (in_new_day),
    .in_day_count  (in_day_count),
    .out_year_out  (out_year_out),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .cmd           (cmd),
    .status        (status)
  );

  assign out_date_ok = (out_day_out != '0) && (out_month_out >= MONTH_JAN)
                     && (out_month_out <= MONTH_DEC);

  `CDA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
  `CDA_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !(out_valid && out_stall), "lost result")
  `CDA_ASSERT_NOW(a_result_in_range, out_valid, out_date_ok, "result date out of range")

endmodule

// ===== tb/tb_calendar_date_add_days.sv =====
`timescale 1ns / 1ps

module tb_calendar_date_add_days;
  import cda_pkg::*;

  typedef struct {
    logic               cmd;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [15:0]        count;
  } command_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } date_t;

  // Tracks the calendar date and queues the date that each command should return.
  class date_tracker;
    date_t              pending_dates[$];
    logic [YEAR_W-1:0]  year  = '0;
    logic [MONTH_W-1:0] month = MONTH_JAN;
    logic [DAY_W-1:0]   day   = 5'd1;
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        sets;
    int unsigned        adds;
    int unsigned        year_wraps;
    longint unsigned    days_added;

    function automatic bit leap_year(logic [YEAR_W-1:0] y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function automatic int unsigned days_in_month(logic [YEAR_W-1:0] y,
                                                  logic [MONTH_W-1:0] m);
      case (m)
        MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
        MONTH_FEB: return leap_year(y) ? 29 : 28;
        default: return 31;
      endcase
    endfunction

    function void note_command(command_t c);
      logic [MONTH_W-1:0] m;
      int unsigned        len;
      int unsigned        d;
      longint unsigned    left;
      if (c.cmd == CMD_SET) begin
        m = c.month;
        if (m < MONTH_JAN) m = MONTH_JAN;
        if (m > MONTH_DEC) m = MONTH_DEC;
        len = days_in_month(c.year, m);
        d = 32'(c.day);
        if (d < 1) d = 1;
        if (d > len) d = len;
        year  = c.year;
        month = m;
        day   = DAY_W'(d);
        sets++;
      end else begin
        left = c.count & ((64'd1 << DAY_COUNT_BITS) - 1);
        days_added += left;
        d = 32'(day);
        len = days_in_month(year, month);
        // roll whole months off until the remainder fits in the current month
        while (d + left > len) begin
          left -= len - d;
          d = 0;
          if (month == MONTH_DEC) begin
            month = MONTH_JAN;
            if (year == '1) year_wraps++;
            year++;
          end else begin
            month++;
          end
          len = days_in_month(year, month);
        end
        day = DAY_W'(d + left);
        adds++;
      end
      pending_dates.push_back('{year, month, day});
    endfunction

    function void check_date(logic [YEAR_W-1:0] y, logic [MONTH_W-1:0] m,
                             logic [DAY_W-1:0] d);
      date_t want;
      checked++;
      if (pending_dates.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected date %0d-%0d-%0d with nothing pending", $time, y, m, d);
        return;
      end
      want = pending_dates.pop_front();
      if (y !== want.year) begin
        mismatches++;
        $display("%0t: year mismatch, expected %0d, got %0d", $time, want.year, y);
      end
      if (m !== want.month) begin
        mismatches++;
        $display("%0t: month mismatch, expected %0d, got %0d", $time, want.month, m);
      end
      if (d !== want.day) begin
        mismatches++;
        $display("%0t: day mismatch, expected %0d, got %0d", $time, want.day, d);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic               in_command;
  logic [YEAR_W-1:0]  in_new_year;
  logic [MONTH_W-1:0] in_new_month;
  logic [DAY_W-1:0]   in_new_day;
  logic [15:0]        in_day_count;
  logic               out_valid;
  logic               out_stall;
  logic [YEAR_W-1:0]  out_year_out;
  logic [MONTH_W-1:0] out_month_out;
  logic [DAY_W-1:0]   out_day_out;

  date_tracker calendar;
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;

  calendar_date_add_days i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_new_year  (in_new_year),
    .in_new_month (in_new_month),
    .in_new_day   (in_new_day),
    .in_day_count (in_day_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_year_out (out_year_out),
    .out_month_out(out_month_out),
    .out_day_out  (out_day_out)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      calendar.check_date(out_year_out, out_month_out, out_day_out);
    end
  end

  function automatic command_t set_cmd(int unsigned y, int unsigned m, int unsigned d);
    command_t c;
    c.cmd   = CMD_SET;
    c.year  = YEAR_W'(y);
    c.month = MONTH_W'(m);
    c.day   = DAY_W'(d);
    c.count = 16'($urandom);
    return c;
  endfunction

  function automatic command_t add_cmd(int unsigned n);
    command_t c;
    c.cmd   = CMD_ADD;
    c.year  = YEAR_W'($urandom);
    c.month = MONTH_W'($urandom);
    c.day   = DAY_W'($urandom);
    c.count = 16'(n);
    return c;
  endfunction

  function automatic command_t random_command();
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    pick = $urandom_range(99);
    if (pick < 28) begin
      pick = $urandom_range(99);
      if (pick < 30) y = $urandom_range(65535);
      else if (pick < 50) y = $urandom_range(65535, 65520);
      else if (pick < 65) y = $urandom_range(163) * 400;
      else if (pick < 80) y = $urandom_range(655) * 100;
      else y = $urandom_range(2110, 1890);
      // mostly legal months, some out of range
      m = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(12, 1);
      return set_cmd(y, m, $urandom_range(31));
    end
    pick = $urandom_range(99);
    if (pick < 55) return add_cmd($urandom_range(62));
    if (pick < 82) return add_cmd($urandom_range(1500));
    if (pick < 95) return add_cmd($urandom_range(20000, 1501));
    return add_cmd($urandom_range(65535));
  endfunction

  task automatic send_command(command_t c);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      // idle with junk on the payload
      in_valid     = 1'b0;
      in_command   = 1'($urandom);
      in_new_year  = YEAR_W'($urandom);
      in_new_month = MONTH_W'($urandom);
      in_new_day   = DAY_W'($urandom);
      in_day_count = 16'($urandom);
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_command   = c.cmd;
    in_new_year  = c.year;
    in_new_month = c.month;
    in_new_day   = c.day;
    in_day_count = c.count;
    do @(posedge clk); while (in_stall);
    calendar.note_command(c);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic run_random(int unsigned n);
    repeat (n) send_command(random_command());
  endtask

  initial begin
    calendar       = new();
    send_gap_pct   = 18;
    recv_stall_pct = 48;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_command     = CMD_SET;
    in_new_year    = '0;
    in_new_month   = MONTH_JAN;
    in_new_day     = '0;
    in_day_count   = '0;
    out_stall      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset date, leap rules, clamping, wrap, extreme counts
    send_command(add_cmd(0));
    send_command(add_cmd(59));
    send_command(set_cmd(1900, MONTH_FEB, 31));
    send_command(add_cmd(1));
    send_command(set_cmd(2000, MONTH_FEB, 30));
    send_command(set_cmd(2100, MONTH_FEB, 29));
    send_command(set_cmd(400, MONTH_FEB, 29));
    send_command(set_cmd(2024, 0, 0));
    send_command(set_cmd(2023, 13, 31));
    send_command(set_cmd(2023, 15, 5));
    send_command(set_cmd(0, 0, 0));
    send_command(set_cmd(0, MONTH_APR, 31));
    send_command(add_cmd(65535));
    send_command(set_cmd(65535, MONTH_DEC, 31));
    send_command(add_cmd(1));
    send_command(set_cmd(65535, 15, 31));
    send_command(add_cmd(65535));
    send_command(add_cmd(0));
    send_command(set_cmd(1, MONTH_JAN, 1));
    send_command(add_cmd(365));
    send_command(set_cmd(2019, MONTH_JUN, 30));
    send_command(add_cmd(1));
    send_command(set_cmd(1999, MONTH_DEC, 31));
    send_command(add_cmd(60));

    run_random(85);
    send_gap_pct   = 48;
    recv_stall_pct = 18;
    run_random(85);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    run_random(85);
    drop_valid();

    while (calendar.pending_dates.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Ran %0d set and %0d add transactions, %0d days added in all, %0d year wraps;",
             calendar.sets, calendar.adds, calendar.days_added, calendar.year_wraps);
    $display("checked %0d dates under three sender/receiver stall mixes, %0d mismatches.",
             calendar.checked, calendar.mismatches);
    if (calendar.mismatches == 0) begin
      $display("tb_calendar_date_add_days passed");
    end else begin
      $display("tb_calendar_date_add_days failed");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("Timeout with %0d dates still pending", calendar.pending_dates.size());
    $display("tb_calendar_date_add_days failed");
    $finish;
  end

endmodule
